// File: rtl/b2da_pkg.sv
package b2da_pkg;

    localparam int MAX_DIGITS_DEF = 10;
    localparam int VALUE_W        = 32;
    localparam int MODE_W         = 2;
    localparam int CHAR_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int CNT_W          = 4;
    localparam int POW_W          = 34;
    localparam int CONV_W         = $clog2(VALUE_W);

    localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_SIGN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_DIGITS = 2'd2;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    typedef enum logic [1:0] {
        SEL_SIGN,
        SEL_POINT,
        SEL_DIGIT,
        SEL_ERR
    } t_char_sel;

    typedef struct packed {
        logic             load;
        logic             sat;
        logic             shift;
        logic             emit;
        t_char_sel        sel;
        logic             last;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] digits;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [POW_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [POW_W-1:0] p;
        case (n)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            4'd10:   p = 34'd10000000000;
            default: p = 34'd10000000000;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/b2da_ctrl.sv
module b2da_ctrl #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [b2da_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [b2da_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic [b2da_pkg::MODE_W-1:0]     i_mode,
    output logic                            o_s_tready,
    output b2da_pkg::t_cmd                  o_cmd,
    input  b2da_pkg::t_status               i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_SAT,
        S_CONV,
        S_SIGN,
        S_DIGIT
    } t_state;

    localparam logic [b2da_pkg::CNT_W-1:0]  MAXD     = b2da_pkg::CNT_W'(MAX_DIGITS);
    localparam logic [b2da_pkg::CONV_W-1:0] CONV_TOP = b2da_pkg::CONV_W'(b2da_pkg::VALUE_W - 1);

    t_state                          r_state;
    logic [b2da_pkg::CNT_W-1:0]      r_digit_count;
    logic                            r_show_sign;
    logic [b2da_pkg::CNT_W-1:0]      r_frac;
    logic [b2da_pkg::CONV_W-1:0]     r_cnt;
    logic [b2da_pkg::CNT_W-1:0]      r_pos;
    logic                            r_pt_done;

    logic [b2da_pkg::CNT_W-1:0]      n_eff;
    logic                            point_here;
    logic                            accept;
    logic                            bad_req;

    always_comb begin
        n_eff      = (r_digit_count > MAXD) ? MAXD : r_digit_count;
        point_here = (r_frac != '0) && (r_frac <= n_eff) && !r_pt_done
                     && (r_pos == r_frac - 1'b1);
        accept     = i_s_tvalid && (r_state == S_IDLE);
        bad_req    = (n_eff == '0)
                     || !(i_mode == b2da_pkg::MODE_UNSIGNED || i_mode == b2da_pkg::MODE_SIGNED);
        o_s_tready = (r_state == S_IDLE);
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.sel    = b2da_pkg::SEL_DIGIT;
        o_cmd.idx    = r_pos;
        o_cmd.digits = n_eff;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept && !bad_req;
            end
            S_ERR: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = b2da_pkg::SEL_ERR;
                o_cmd.last = 1'b1;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
            end
            S_SIGN: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = b2da_pkg::SEL_SIGN;
            end
            S_DIGIT: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = point_here ? b2da_pkg::SEL_POINT : b2da_pkg::SEL_DIGIT;
                o_cmd.last = !point_here && (r_pos == '0);
            end
            default: begin
                o_cmd.sel = b2da_pkg::SEL_DIGIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_digit_count <= 4'd3;
            r_show_sign   <= 1'b0;
            r_frac        <= 4'd0;
            r_cnt         <= '0;
            r_pos         <= '0;
            r_pt_done     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    b2da_pkg::CFG_DIGIT_COUNT:     r_digit_count <= i_cfg_data;
                    b2da_pkg::CFG_SHOW_SIGN:       r_show_sign   <= i_cfg_data[0];
                    b2da_pkg::CFG_FRACTION_DIGITS: r_frac        <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= bad_req ? S_ERR : S_SAT;
                    end
                end
                S_ERR: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SAT: begin
                    r_state   <= S_CONV;
                    r_cnt     <= CONV_TOP;
                    r_pos     <= n_eff - 1'b1;
                    r_pt_done <= 1'b0;
                end
                S_CONV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= r_show_sign ? S_SIGN : S_DIGIT;
                    end
                end
                S_SIGN: begin
                    if (i_status.out_free) begin
                        r_state <= S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    if (i_status.out_free) begin
                        if (point_here) begin
                            r_pt_done <= 1'b1;
                        end else if (r_pos == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos <= r_pos - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/b2da_dp.sv
module b2da_dp #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [b2da_pkg::MODE_W-1:0]      i_mode,
    input  logic [b2da_pkg::VALUE_W-1:0]     i_unsigned_value,
    input  logic [b2da_pkg::VALUE_W-1:0]     i_signed_value,
    input  b2da_pkg::t_cmd                   i_cmd,
    output b2da_pkg::t_status                o_status,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [b2da_pkg::CHAR_W-1:0]      o_m_tdata,
    output logic                             o_m_tuser,
    output logic                             o_m_tlast
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int SEL_W = $clog2(BCD_W);

    logic [b2da_pkg::VALUE_W-1:0] r_mag;
    logic                         r_neg;
    logic [BCD_W-1:0]             r_bcd;
    logic                         r_valid;
    logic [b2da_pkg::CHAR_W-1:0]  r_char;
    logic                         r_ok;
    logic                         r_last;

    logic [b2da_pkg::VALUE_W-1:0] n_mag_load;
    logic [BCD_W-1:0]             bcd_adj;
    logic [b2da_pkg::POW_W-1:0]   lim;
    logic [SEL_W-1:0]             digit_lsb;
    logic [3:0]                   digit;
    logic [b2da_pkg::CHAR_W-1:0]  n_char;

    always_comb begin
        if (i_mode == b2da_pkg::MODE_SIGNED && i_signed_value[b2da_pkg::VALUE_W-1]) begin
            n_mag_load = ~i_signed_value + 1'b1;
        end else if (i_mode == b2da_pkg::MODE_SIGNED) begin
            n_mag_load = i_signed_value;
        end else begin
            n_mag_load = i_unsigned_value;
        end
        for (int k = 0; k < MAX_DIGITS; k++) begin
            bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                          : r_bcd[4*k +: 4];
        end
        lim       = b2da_pkg::pow10(i_cmd.digits);
        digit_lsb = SEL_W'({i_cmd.idx, 2'b00});
        digit     = r_bcd[digit_lsb +: 4];
        case (i_cmd.sel)
            b2da_pkg::SEL_SIGN:  n_char = r_neg ? b2da_pkg::CH_MINUS : b2da_pkg::CH_PLUS;
            b2da_pkg::SEL_POINT: n_char = b2da_pkg::CH_POINT;
            b2da_pkg::SEL_DIGIT: n_char = b2da_pkg::CH_ZERO + {4'd0, digit};
            default:             n_char = b2da_pkg::CH_NONE;
        endcase
        o_status.out_free = !r_valid || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= n_mag_load;
            r_neg <= (i_mode == b2da_pkg::MODE_SIGNED) && i_signed_value[b2da_pkg::VALUE_W-1];
            r_bcd <= '0;
        end else if (i_cmd.sat) begin
            if ({2'b00, r_mag} >= lim) begin
                r_mag <= b2da_pkg::VALUE_W'(lim - 1'b1);
            end
        end else if (i_cmd.shift) begin
            r_bcd <= {bcd_adj[BCD_W-2:0], r_mag[b2da_pkg::VALUE_W-1]};
            r_mag <= {r_mag[b2da_pkg::VALUE_W-2:0], 1'b0};
        end
        if (i_cmd.emit) begin
            r_char <= n_char;
            r_ok   <= (i_cmd.sel != b2da_pkg::SEL_ERR);
            r_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_char;
    assign o_m_tuser  = r_ok;
    assign o_m_tlast  = r_last;

endmodule

// File: rtl/binary_to_decimal_ascii_formatter_top.sv
// Formats one 32-bit number per request as fixed-width ASCII decimal text.
// The slave channel takes a request: tuser holds the mode (0 unsigned, 1 signed)
// and tdata holds the unsigned value in bits 31:0 and the signed value in 63:32.
// The master channel returns one character per transfer in tdata, with the ok
// flag in tuser and tlast on the final character of the request.
// The configuration channel writes digit count (index 0), sign enable (index 1)
// and fraction digits (index 2); it is always ready. It must be written while
// idle, which the block itself does not enforce. A request is loaded, saturated
// to the digit count and converted by serial double-dabble, then sent at one
// character per cycle while the receiver is ready, the sign first if enabled.
// The slave side is ready only between requests. A bad mode or a zero digit
// count returns a single character of zero with ok low and tlast high.
// When the receiver stalls, the output register holds the character and the
// controller waits. Reset returns to idle with digit count 3, no sign and no
// decimal point, and drops any pending character.
module binary_to_decimal_ascii_formatter_top #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [b2da_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [b2da_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [63:0]                     i_s_tdata,  // unsigned_value, signed_value
    input  logic [b2da_pkg::MODE_W-1:0]     i_s_tuser,  // mode
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [b2da_pkg::CHAR_W-1:0]     o_m_tdata,  // character
    output logic                            o_m_tuser,  // ok
    output logic                            o_m_tlast
);

    b2da_pkg::t_cmd    cmd;
    b2da_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    b2da_ctrl #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .i_mode     (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    b2da_dp #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_s_tuser),
        .i_unsigned_value(i_s_tdata[31:0]),
        .i_signed_value  (i_s_tdata[63:32]),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_m_tdata       (o_m_tdata),
        .o_m_tuser       (o_m_tuser),
        .o_m_tlast       (o_m_tlast)
    );

`ifndef SYNTHESIS
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("slave side ready right after a request");

    a_error_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && o_m_tdata == b2da_pkg::CH_NONE))
        else $error("error result is not a single zero character");

    a_char_is_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == b2da_pkg::CH_PLUS
            || o_m_tdata == b2da_pkg::CH_MINUS || o_m_tdata == b2da_pkg::CH_POINT
            || (o_m_tdata >= b2da_pkg::CH_ZERO && o_m_tdata <= b2da_pkg::CH_NINE)))
        else $error("character outside the decimal set");
`endif

endmodule

// File: tb/binary_to_decimal_ascii_formatter_top_test.sv
module binary_to_decimal_ascii_formatter_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import b2da_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_BAD_2 = 2'd2;
    localparam logic [MODE_W-1:0]    MODE_BAD_3 = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int                   CYCLE_LIMIT = 200000;

    class decimal_text_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] ch;
            logic              ok;
            logic              last;
        } t_text_char;

        t_text_char expected_chars[$];
        logic [3:0] digit_count     = 4'd3;
        logic       show_sign       = 1'b0;
        logic [3:0] fraction_digits = 4'd0;
        int         errors          = 0;

        static function longint unsigned ten_to(int n);
            longint unsigned p;
            int i;
            p = 1;
            for (i = 0; i < n; i++) p = p * 10;
            return p;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DIGIT_COUNT:     digit_count = data;
                CFG_SHOW_SIGN:       show_sign = data[0];
                CFG_FRACTION_DIGITS: fraction_digits = data;
                default: ;
            endcase
        endfunction

        function void push_char(logic [CHAR_W-1:0] ch, logic ok, logic last);
            t_text_char c;
            c.ch = ch;
            c.ok = ok;
            c.last = last;
            expected_chars.push_back(c);
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [31:0] uval,
                                   logic [31:0] sval);
            int n;
            int i;
            int d;
            longint unsigned mag;
            logic neg;
            n = (digit_count > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : int'(digit_count);
            if (n == 0 || (mode != MODE_UNSIGNED && mode != MODE_SIGNED)) begin
                push_char(CH_NONE, 1'b0, 1'b1);
                return;
            end
            neg = (mode == MODE_SIGNED) && sval[31];
            if (mode == MODE_UNSIGNED) begin
                mag = uval;
            end else if (neg) begin
                mag = 64'h1_0000_0000 - {32'd0, sval};
            end else begin
                mag = sval;
            end
            if (mag >= ten_to(n)) mag = ten_to(n) - 1;
            if (show_sign) push_char(neg ? CH_MINUS : CH_PLUS, 1'b1, 1'b0);
            for (i = 0; i < n; i++) begin
                if (fraction_digits != 0 && int'(fraction_digits) <= n
                        && n - int'(fraction_digits) == i) begin
                    push_char(CH_POINT, 1'b1, 1'b0);
                end
                d = int'((mag / ten_to(n - 1 - i)) % 10);
                push_char(CH_ZERO + CHAR_W'(d), 1'b1, i == n - 1);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_char(logic [CHAR_W-1:0] ch, logic ok, logic last);
            t_text_char c;
            if (expected_chars.size() == 0) begin
                report($sformatf("character %h with no request pending", ch));
            end else begin
                c = expected_chars.pop_front();
                if (ch !== c.ch) report($sformatf("character %h, expected %h", ch, c.ch));
                if (ok !== c.ok) report($sformatf("ok %b, expected %b", ok, c.ok));
                if (last !== c.last) report($sformatf("last %b, expected %b", last, c.last));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [63:0]           i_s_tdata;
    logic [MODE_W-1:0]     i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [CHAR_W-1:0]     o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    decimal_text_scoreboard sb = new;
    bit quiet = 1'b0;
    int hold_len = 0;
    int cycles = 0;

    binary_to_decimal_ascii_formatter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("binary_to_decimal_ascii_formatter_top_test: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_char(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    initial begin
        int n;
        i_m_tready <= 1'b0;
        forever begin
            if (hold_len != 0) begin
                n = hold_len;
                hold_len = 0;
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    task configure(logic [3:0] dc, logic [3:0] sg, logic [3:0] fr, bit with_unused);
        if (with_unused) write_reg(CFG_UNUSED, 4'hF);
        write_reg(CFG_DIGIT_COUNT, dc);
        write_reg(CFG_SHOW_SIGN, sg);
        write_reg(CFG_FRACTION_DIGITS, fr);
        i_cfg_valid <= 1'b0;
    endtask

    task send_request(logic [MODE_W-1:0] mode, logic [31:0] uval, logic [31:0] sval);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {sval, uval};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(mode, uval, sval);
    endtask

    task finish_phase();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(int n);
        longint unsigned lim;
        logic [31:0] v;
        lim = decimal_text_scoreboard::ten_to(n);
        case ($urandom_range(0, 4))
            0: v = (n > 9) ? $urandom : 32'($urandom % lim);
            1: v = (n > 9) ? 32'hFFFF_FFFF : 32'(lim - 1);
            2: v = (n > 9) ? $urandom : 32'(lim);
            3: v = 32'd0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task send_random(int n);
        logic [MODE_W-1:0] mode;
        logic [31:0] uval;
        logic [31:0] sval;
        logic [31:0] mag;
        mode = ($urandom_range(0, 9) < 9) ? MODE_W'($urandom_range(0, 1))
                                         : MODE_W'($urandom_range(2, 3));
        mag = pick_value(n);
        uval = (mode == MODE_UNSIGNED) ? mag : $urandom;
        if (mode == MODE_SIGNED) begin
            sval = $urandom_range(0, 1) ? -mag : mag;
        end else begin
            sval = $urandom;
        end
        send_request(mode, uval, sval);
    endtask

    initial begin
        int ph;
        int dc;
        int eff;
        int fr;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_DIGIT_COUNT;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= MODE_UNSIGNED;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: three digits, no sign, no point.
        send_request(MODE_UNSIGNED, 32'd0, 32'd0);
        send_request(MODE_UNSIGNED, 32'd999, 32'hFFFF_FFFF);
        send_request(MODE_UNSIGNED, 32'd1000, 32'd0);
        send_request(MODE_UNSIGNED, 32'hFFFF_FFFF, 32'd5);
        send_request(MODE_BAD_2, 32'd12, 32'd12);
        send_request(MODE_BAD_3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        finish_phase();

        configure(4'd10, 4'd1, 4'd0, 1'b0);
        send_request(MODE_UNSIGNED, 32'hFFFF_FFFF, 32'd0);
        send_request(MODE_SIGNED, 32'd0, 32'h8000_0000);
        send_request(MODE_SIGNED, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(MODE_SIGNED, 32'd0, 32'hFFFF_FFFF);
        send_request(MODE_SIGNED, 32'd77, 32'd0);
        finish_phase();

        configure(4'd15, 4'd1, 4'd10, 1'b1);
        send_request(MODE_SIGNED, 32'd0, -32'd123456);
        send_request(MODE_UNSIGNED, 32'd1234567890, 32'd0);
        finish_phase();

        configure(4'd4, 4'd0, 4'd2, 1'b0);
        send_request(MODE_UNSIGNED, 32'd1234, 32'd0);
        send_request(MODE_UNSIGNED, 32'd10000, 32'd0);
        send_request(MODE_SIGNED, 32'd0, -32'd5);
        finish_phase();

        configure(4'd4, 4'd1, 4'd5, 1'b0);
        send_request(MODE_SIGNED, 32'd0, -32'd42);
        send_request(MODE_UNSIGNED, 32'd7, 32'd0);
        finish_phase();

        configure(4'd0, 4'd1, 4'd0, 1'b0);
        send_request(MODE_UNSIGNED, 32'd5, 32'd5);
        finish_phase();

        configure(4'd1, 4'b1110, 4'd15, 1'b0);
        send_request(MODE_UNSIGNED, 32'd9, 32'd0);
        send_request(MODE_UNSIGNED, 32'd10, 32'd0);
        finish_phase();

        configure(4'd1, 4'd1, 4'd1, 1'b0);
        send_request(MODE_SIGNED, 32'd0, -32'd3);
        finish_phase();

        for (ph = 0; ph < 8; ph++) begin
            dc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10);
            eff = (dc > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : dc;
            fr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, eff);
            configure(4'(dc), 4'($urandom_range(0, 15)), 4'(fr), ph == 3);
            quiet = (ph == 7);
            if (ph == 2) hold_len = 300;
            repeat (10) send_random(eff);
            finish_phase();
        end

        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
            $display("binary_to_decimal_ascii_formatter_top_test: done, clean");
        end else begin
            $display("binary_to_decimal_ascii_formatter_top_test: done, errors");
        end
        $finish;
    end

endmodule
